/* rtl/biou_pkg.sv */
// Shared types and constants for the box overlap ratio unit.
// No dependencies; imported by every module of the block.
package biou_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = FRAC_BITS + 1;
  localparam int AREA_W    = 2 * COORD_W;
  localparam int UNION_W   = AREA_W + 1;
  localparam int REM_W     = UNION_W + 1;
  localparam int RATIO_W   = FRAC_BITS + 1;
  // extents, products, divider input capture, RATIO_W divider stages, output
  localparam int LATENCY   = RATIO_W + 4;

  localparam logic [COORD_W-1:0] THRESH_RESET = COORD_W'(1) << (FRAC_BITS - 1);
  localparam logic [RATIO_W-1:0] RATIO_ONE    = RATIO_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] first_xmin;
    logic [COORD_W-1:0] first_ymin;
    logic [COORD_W-1:0] first_xmax;
    logic [COORD_W-1:0] first_ymax;
    logic [COORD_W-1:0] second_xmin;
    logic [COORD_W-1:0] second_ymin;
    logic [COORD_W-1:0] second_xmax;
    logic [COORD_W-1:0] second_ymax;
  } biou_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] overlap_ratio;
    logic               meets_threshold;
    logic               empty_union;
  } biou_out_t;

  function automatic logic [COORD_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

/* rtl/biou_divider.sv */
// Pipelined restoring divider: intersection * 2^FRAC_BITS / union, one
// quotient bit per stage. Depends on biou_pkg.
module biou_divider
  import biou_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [AREA_W-1:0]  in_inter,
  input  logic [UNION_W-1:0] in_union,
  input  logic               in_empty,
  output logic               out_valid,
  output logic [RATIO_W-1:0] out_quot,
  output logic               out_empty
);

  logic               vld_r [0:RATIO_W];
  logic [UNION_W-1:0] rem_r [0:RATIO_W];
  logic [UNION_W-1:0] div_r [0:RATIO_W];
  logic [RATIO_W-1:0] quo_r [0:RATIO_W];
  logic               emp_r [0:RATIO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0] <= UNION_W'(in_inter);
    div_r[0] <= in_union;
    quo_r[0] <= '0;
    emp_r[0] <= in_empty;
  end

  for (genvar k = 0; k < RATIO_W; k++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             ge;

    // first stage tests the integer bit, later ones shift in a zero
    assign trial = (k == 0) ? {1'b0, rem_r[k]} : {rem_r[k], 1'b0};
    assign diff  = trial - {1'b0, div_r[k]};
    assign ge    = ~diff[REM_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1] <= ge ? diff[UNION_W-1:0] : trial[UNION_W-1:0];
      div_r[k+1] <= div_r[k];
      quo_r[k+1] <= {quo_r[k][RATIO_W-2:0], ge};
      emp_r[k+1] <= emp_r[k];
    end
  end

  assign out_valid = vld_r[RATIO_W];
  assign out_quot  = quo_r[RATIO_W];
  assign out_empty = emp_r[RATIO_W];

endmodule

/* rtl/box_iou_threshold_unit.sv */
// Top level of the box overlap ratio (IoU) unit with threshold test.
// Depends on biou_pkg and biou_divider.
//
// Takes one box pair per clock whenever start is high; busy is always low.
// Each request gives exactly one result, strobed by out_valid. The pipeline
// has one stage for the edge extents, one for the three 17x17 products,
// then the divider, which resolves one quotient bit per stage, and an output
// register that applies the threshold. The receiver cannot stall the unit.
// The threshold is written through cfg_valid/cfg_data (always ready); the
// user must write it only while no request is in flight, as the unit does
// not enforce this.
module box_iou_threshold_unit
  import biou_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  biou_in_t           in_box,
  output logic               out_valid,
  output biou_out_t          out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COORD_W-1:0] cfg_data
);

  logic [COORD_W-1:0] thr_r;
  logic               fire;

  logic               s1_vld_r;
  logic [COORD_W-1:0] wa_r, ha_r, wb_r, hb_r, wi_r, hi_r;

  logic               s2_vld_r;
  logic [AREA_W-1:0]  area_a_r, area_b_r, inter_r;

  logic [UNION_W-1:0] uni;
  logic               uni_empty;

  logic               dv_vld;
  logic [RATIO_W-1:0] dv_quot;
  logic               dv_empty;

  logic               out_vld_r;
  biou_out_t          out_res_r;
  biou_out_t          out_res_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign fire      = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // extents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= fire;
    end
    wa_r <= extent(in_box.first_xmin, in_box.first_xmax);
    ha_r <= extent(in_box.first_ymin, in_box.first_ymax);
    wb_r <= extent(in_box.second_xmin, in_box.second_xmax);
    hb_r <= extent(in_box.second_ymin, in_box.second_ymax);
    wi_r <= extent((in_box.first_xmin > in_box.second_xmin) ? in_box.first_xmin
                                                            : in_box.second_xmin,
                   (in_box.first_xmax < in_box.second_xmax) ? in_box.first_xmax
                                                            : in_box.second_xmax);
    hi_r <= extent((in_box.first_ymin > in_box.second_ymin) ? in_box.first_ymin
                                                            : in_box.second_ymin,
                   (in_box.first_ymax < in_box.second_ymax) ? in_box.first_ymax
                                                            : in_box.second_ymax);
  end

  // areas
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    area_a_r <= AREA_W'(wa_r) * AREA_W'(ha_r);
    area_b_r <= AREA_W'(wb_r) * AREA_W'(hb_r);
    inter_r  <= AREA_W'(wi_r) * AREA_W'(hi_r);
  end

  // inter never exceeds either area
  assign uni       = UNION_W'(area_a_r) + UNION_W'(area_b_r) - UNION_W'(inter_r);
  assign uni_empty = (uni == '0);

  biou_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_inter  (inter_r),
    .in_union  (uni),
    .in_empty  (uni_empty),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_empty (dv_empty)
  );

  always_comb begin
    out_res_nxt.overlap_ratio   = dv_empty ? '0 : dv_quot;
    out_res_nxt.meets_threshold = (out_res_nxt.overlap_ratio >= thr_r);
    out_res_nxt.empty_union     = dv_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_ratio_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.overlap_ratio <= RATIO_ONE))
    else $error("overlap ratio above 1.0");

  a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.empty_union) |-> (out_res.overlap_ratio == '0))
    else $error("empty union with nonzero ratio");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for box_iou_threshold_unit: directed and random box pairs, with
// threshold writes between phases. Results are checked against an in-bench predictor.
// Depends on biou_pkg and the box_iou_threshold_unit RTL.
module testbench;
  import biou_pkg::*;

  localparam int CLK_HALF  = 4;
  localparam int RUN_LIMIT = 200000;
  localparam int UNIT      = 1 << FRAC_BITS;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  biou_in_t           in_box    = '0;
  logic               out_valid;
  biou_out_t          out_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COORD_W-1:0] cfg_data  = '0;

  logic [COORD_W-1:0] model_threshold = THRESH_RESET;
  biou_out_t          expected_results[$];
  int                 mismatches  = 0;
  int                 cycle_count = 0;
  bit                 allow_gaps  = 1'b1;

  box_iou_threshold_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_box    (in_box),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] span(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  function automatic logic [COORD_W-1:0] smaller(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [COORD_W-1:0] larger(logic [COORD_W-1:0] a,
                                                logic [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic biou_out_t predict_overlap(biou_in_t b, logic [COORD_W-1:0] thr);
    logic [63:0] area_first, area_second, common, union_area, ratio;
    biou_out_t   r;
    area_first  = span(b.first_xmin, b.first_xmax) * span(b.first_ymin, b.first_ymax);
    area_second = span(b.second_xmin, b.second_xmax) * span(b.second_ymin, b.second_ymax);
    common = span(larger(b.first_xmin, b.second_xmin), smaller(b.first_xmax, b.second_xmax))
           * span(larger(b.first_ymin, b.second_ymin), smaller(b.first_ymax, b.second_ymax));
    union_area = area_first + area_second - common;
    if (union_area == 0) begin
      ratio = 64'd0;
    end else begin
      ratio = (common << FRAC_BITS) / union_area;
      if (ratio > 64'(UNIT)) ratio = 64'(UNIT);
    end
    r.overlap_ratio   = ratio[RATIO_W-1:0];
    r.meets_threshold = (ratio >= 64'(thr));
    r.empty_union     = (union_area == 0);
    return r;
  endfunction

  function automatic biou_in_t box_of(int ax0, int ay0, int ax1, int ay1,
                                      int bx0, int by0, int bx1, int by1);
    biou_in_t b;
    b.first_xmin  = ax0[COORD_W-1:0];
    b.first_ymin  = ay0[COORD_W-1:0];
    b.first_xmax  = ax1[COORD_W-1:0];
    b.first_ymax  = ay1[COORD_W-1:0];
    b.second_xmin = bx0[COORD_W-1:0];
    b.second_ymin = by0[COORD_W-1:0];
    b.second_xmax = bx1[COORD_W-1:0];
    b.second_ymax = by1[COORD_W-1:0];
    return b;
  endfunction

  // {lo, hi} inside [0, 1.0]
  function automatic logic [2*COORD_W-1:0] ordered_pair();
    logic [COORD_W-1:0] a, c;
    a = COORD_W'($urandom_range(0, UNIT));
    c = COORD_W'($urandom_range(0, UNIT));
    return (a < c) ? {a, c} : {c, a};
  endfunction

  function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] v, int reach);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * reach)) - reach;
    if (t < 0) t = 0;
    if (t > UNIT) t = UNIT;
    return t[COORD_W-1:0];
  endfunction

  function automatic biou_in_t random_box();
    biou_in_t    b;
    int unsigned mode;
    int          reach;
    mode = $urandom_range(0, 99);
    {b.first_xmin, b.first_xmax}   = ordered_pair();
    {b.first_ymin, b.first_ymax}   = ordered_pair();
    {b.second_xmin, b.second_xmax} = ordered_pair();
    {b.second_ymin, b.second_ymax} = ordered_pair();
    if (mode < 55) begin
      // second box is a jittered copy of the first
      reach = 1 << $urandom_range(0, 15);
      b.second_xmin = nudge(b.first_xmin, reach);
      b.second_ymin = nudge(b.first_ymin, reach);
      b.second_xmax = nudge(b.first_xmax, reach);
      b.second_ymax = nudge(b.first_ymax, reach);
    end else if (mode >= 80 && mode < 92) begin
      b.first_xmin  = COORD_W'($urandom_range(0, COORD_MAX));
      b.first_ymin  = COORD_W'($urandom_range(0, COORD_MAX));
      b.first_xmax  = COORD_W'($urandom_range(0, COORD_MAX));
      b.first_ymax  = COORD_W'($urandom_range(0, COORD_MAX));
      b.second_xmin = COORD_W'($urandom_range(0, COORD_MAX));
      b.second_ymin = COORD_W'($urandom_range(0, COORD_MAX));
      b.second_xmax = COORD_W'($urandom_range(0, COORD_MAX));
      b.second_ymax = COORD_W'($urandom_range(0, COORD_MAX));
    end else if (mode >= 92) begin
      case ($urandom_range(0, 3))
        0: {b.first_xmax, b.first_xmin} = {b.first_xmin, b.first_xmax};
        1: b.first_ymax = b.first_ymin;
        2: {b.second_ymax, b.second_ymin} = {b.second_ymin, b.second_ymax};
        default: begin
          b.first_xmax  = b.first_xmin;
          b.second_ymax = b.second_ymin;
        end
      endcase
    end
    return b;
  endfunction

  task automatic send_box(input biou_in_t b);
    start  <= 1'b1;
    in_box <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results = {expected_results, predict_overlap(b, model_threshold)};
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!allow_gaps || r < 60) return;
    if (r < 90) pause_sender($urandom_range(1, 3));
    else pause_sender($urandom_range(4, 30));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_threshold(input logic [COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_threshold = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // runs at the reset threshold of one half
  task automatic test_directed_boxes();
    send_box(box_of(0, 0, UNIT, UNIT, 0, 0, UNIT, UNIT));
    send_box(box_of(0, 0, 100, 100, 200, 200, 300, 300));
    send_box(box_of(0, 0, 100, 100, 100, 0, 200, 100));
    send_box(box_of(0, 0, 200, 100, 100, 0, 300, 100));
    send_box(box_of(0, 0, 100, 100, 0, 0, 100, 50));
    send_box(box_of(0, 0, UNIT, UNIT, 16384, 16384, 49152, 49152));
    send_box(box_of(500, 0, 100, 100, 0, 0, 100, 100));
    send_box(box_of(0, 0, 100, 100, 0, 90, 100, 10));
    send_box(box_of(900, 900, 100, 100, 50, 50, 800, 800));
    send_box(box_of(10, 10, 10, 50, 20, 20, 60, 20));
    send_box(box_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_box('1);
    send_box(box_of(UNIT, UNIT, int'(COORD_MAX), int'(COORD_MAX),
                    UNIT, UNIT, int'(COORD_MAX), int'(COORD_MAX)));
    send_box(box_of(0, 0, int'(COORD_MAX), int'(COORD_MAX), 0, 0, UNIT, UNIT));
    send_box(box_of(5, 5, 5, 100, 0, 0, 100, 100));
    send_box(box_of(7, 7, 8, 8, 7, 7, 8, 8));
    send_box(box_of(7, 7, 8, 8, 0, 0, UNIT, UNIT));
    send_box(box_of('h0AAAA, 'h05555, 'h15555, 'h1AAAA,
                    'h05555, 'h0AAAA, 'h1AAAA, 'h15555));
    send_box(box_of(0, 0, 30000, 40000, 10000, 5000, 65536, 65536));
    send_box(box_of(1, 1, UNIT, UNIT, 0, 0, UNIT - 1, UNIT - 1));
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    logic [COORD_W-1:0] levels[5];
    levels = '{COORD_W'(0), COORD_W'(1), COORD_W'(UNIT - 1), COORD_W'(UNIT), COORD_MAX};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      send_box(box_of(0, 0, UNIT, UNIT, 0, 0, UNIT, UNIT));
      send_box(box_of(3, 3, 3, 9, 4, 4, 2, 9));
      send_box(box_of(0, 0, 100, 100, 0, 0, 100, 50));
      send_box(box_of(0, 0, 100, 100, 200, 0, 300, 100));
      repeat (6) begin
        send_box(random_box());
        random_gap();
      end
      drain_results();
    end
  endtask

  task automatic test_random_pairs();
    for (int phase = 0; phase < 4; phase++) begin
      write_threshold(COORD_W'($urandom_range(0, UNIT)));
      allow_gaps = (phase != 1);
      for (int n = 0; n < 440; n++) begin
        send_box(random_box());
        if (phase == 0 && n == 220) drain_results();
        else random_gap();
      end
      drain_results();
    end
    allow_gaps = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    biou_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_res);
      end else begin
        want = expected_results.pop_front();
        if (out_res.overlap_ratio !== want.overlap_ratio) begin
          mismatches++;
          $display("%0t: overlap_ratio expected %0d actual %0d",
                   $time, want.overlap_ratio, out_res.overlap_ratio);
        end
        if (out_res.meets_threshold !== want.meets_threshold) begin
          mismatches++;
          $display("%0t: meets_threshold expected %0b actual %0b",
                   $time, want.meets_threshold, out_res.meets_threshold);
        end
        if (out_res.empty_union !== want.empty_union) begin
          mismatches++;
          $display("%0t: empty_union expected %0b actual %0b",
                   $time, want.empty_union, out_res.empty_union);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_boxes();
    test_threshold_extremes();
    test_random_pairs();
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
